@@ sv/erdd_pkg.sv @@
// ============================================================================
// erdd_pkg
// Shared types, constants and the digit font for the echo range display driver.
// ============================================================================
`default_nettype none

package erdd_pkg;

  // Field widths.
  localparam int unsigned OpW      = 2;
  localparam int unsigned CountW   = 16;
  localparam int unsigned DivW     = 8;
  localparam int unsigned DistW    = 10;
  localparam int unsigned SegW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned BcdW     = 12;

  // Operation codes of an input item.
  typedef enum logic [OpW-1:0] {
    OP_ECHO    = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_SCAN    = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_COUNT_DIVISOR  = 2'd0,
    CFG_FAR_THRESHOLD  = 2'd1,
    CFG_NEAR_THRESHOLD = 2'd2,
    CFG_NONE           = 2'd3
  } cfg_idx_t;

  // Reset values.
  localparam logic [DivW-1:0]  DIVISOR_RST = 8'd29;
  localparam logic [DistW-1:0] FAR_RST     = 10'd150;
  localparam logic [DistW-1:0] NEAR_RST    = 10'd80;
  localparam logic [DistW-1:0] DIST_RST    = 10'd400;
  localparam logic [BcdW-1:0]  BCD_RST     = 12'h400;
  localparam logic [DistW-1:0] DIST_MAX    = 10'd999;
  localparam logic [SegW-1:0]  DOT_BIT     = 8'h80;
  localparam logic [SegW-1:0]  PINS_OFF    = 8'hFF;

  // Active-high seven-segment font for decimal digits.
  function automatic logic [SegW-1:0] seg_font(input logic [3:0] digit);
    logic [SegW-1:0] pat;
    case (digit)
      4'd0: pat = 8'h3F;
      4'd1: pat = 8'h06;
      4'd2: pat = 8'h5B;
      4'd3: pat = 8'h4F;
      4'd4: pat = 8'h66;
      4'd5: pat = 8'h6D;
      4'd6: pat = 8'h7D;
      4'd7: pat = 8'h07;
      4'd8: pat = 8'h7F;
      4'd9: pat = 8'h6F;
      default: pat = 8'h3F;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ sv/echo_range_display_driver_unit.sv @@
// Sequence: an echo passes through 16 restoring division steps, one bit per cycle,
//   a saturation step, 10 binary-to-BCD shift steps and the output load. A scan
//   tick passes through its scan step before the load; a timeout or unused op goes
//   straight to the load. Each waits while a stalled result still holds the output register.
// Throughput: one item at a time; the next item can be taken in the cycle after
//   the result is loaded into the output register, even while that result waits.
// Reset (rst_n low, synchronous) restores registers, distance 400 and display off.
// ============================================================================
// echo_range_display_driver_unit
// Converts echo timer counts to a saturated distance in centimeters, keeps its
// decimal digits for a multiplexed active-low display and drives zone LEDs.
// ============================================================================
`default_nettype none

module echo_range_display_driver_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input channel.
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [erdd_pkg::OpW-1:0]          in_op,
  input  wire logic [erdd_pkg::CountW-1:0]       in_echo_count,
  // Result channel.
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [erdd_pkg::SegW-1:0]              out_segment_pins,
  output logic [erdd_pkg::SegW-1:0]              out_digit_select_pins,
  output logic                                   out_red_led_pin,
  output logic                                   out_green_led_pin,
  output logic [erdd_pkg::DistW-1:0]             out_distance_cm,
  // Configuration port.
  input  wire logic                              cfg_we,
  input  wire logic [erdd_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [erdd_pkg::CfgDataW-1:0]     cfg_wdata
);
  import erdd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_SAT  = 6'b000100,
    ST_BCD  = 6'b001000,
    ST_SCAN = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [DivW-1:0]   divisor_r;
  logic [DistW-1:0]  far_r, near_r;
  logic [CountW-1:0] dvd_r, dvd_nxt;
  logic [DivW-1:0]   rem_r, rem_nxt;
  logic [DistW-1:0]  bin_r, bin_nxt;
  logic [BcdW-1:0]   bcd_r, bcd_nxt;
  logic [DistW-1:0]  dist_r, dist_nxt;
  logic [1:0]        scan_r, scan_nxt;
  logic [SegW-1:0]   seg_r, seg_nxt;
  logic [SegW-1:0]   dig_r, dig_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [SegW-1:0]   out_seg_r, out_dig_r;
  logic              out_red_r, out_green_r;
  logic [DistW-1:0]  out_dist_r;

  logic              in_xfer;
  logic              out_free;
  logic              out_load;
  logic [DivW:0]     rem_sh;
  logic              q_bit;
  logic [BcdW-1:0]   bcd_adj;
  logic [3:0]        nib;
  logic [3:0]        scan_digit;
  logic [SegW-1:0]   scan_pat;
  logic              red_lvl, green_lvl;

  assign in_xfer  = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == ST_FIN) && out_free;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      divisor_r <= DIVISOR_RST;
      far_r     <= FAR_RST;
      near_r    <= NEAR_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COUNT_DIVISOR:  divisor_r <= cfg_wdata[DivW-1:0];
        CFG_FAR_THRESHOLD:  far_r     <= cfg_wdata;
        CFG_NEAR_THRESHOLD: near_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // One restoring division step: a zero divisor yields all ones, which saturates.
  always_comb begin
    rem_sh = {rem_r, dvd_r[CountW-1]};
    q_bit  = (rem_sh >= {1'b0, divisor_r});
  end

  // One double-dabble adjust over the three BCD digits.
  always_comb begin
    bcd_adj = bcd_r;
    nib     = '0;
    for (int i = 0; i < 3; i++) begin
      nib = bcd_r[4*i +: 4];
      if (nib >= 4'd5) begin
        bcd_adj[4*i +: 4] = nib + 4'd3;
      end
    end
  end

  // Pattern for the digit at the current scan position; dot on the hundreds.
  always_comb begin
    case (scan_r)
      2'd1:    scan_digit = bcd_r[7:4];
      2'd2:    scan_digit = bcd_r[3:0];
      default: scan_digit = bcd_r[11:8];
    endcase
    scan_pat = seg_font(scan_digit);
    if (scan_r == 2'd0 || scan_r == 2'd3) begin
      scan_pat = scan_pat | DOT_BIT;
    end
  end

  // Zone LEDs from the current distance, active low.
  always_comb begin
    if (dist_r > far_r) begin
      red_lvl   = 1'b1;
      green_lvl = 1'b0;
    end else if (dist_r > near_r) begin
      red_lvl   = 1'b0;
      green_lvl = 1'b0;
    end else begin
      red_lvl   = 1'b0;
      green_lvl = 1'b1;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    dist_nxt  = dist_r;
    scan_nxt  = scan_r;
    seg_nxt   = seg_r;
    dig_nxt   = dig_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          cnt_nxt = '0;
          case (op_t'(in_op))
            OP_ECHO: begin
              dvd_nxt   = in_echo_count;
              rem_nxt   = '0;
              state_nxt = ST_DIV;
            end
            OP_SCAN: state_nxt = ST_SCAN;
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt = q_bit ? DivW'(rem_sh - {1'b0, divisor_r}) : rem_sh[DivW-1:0];
        dvd_nxt = {dvd_r[CountW-2:0], q_bit};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(CountW - 1)) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        dist_nxt  = (dvd_r > CountW'(DIST_MAX)) ? DIST_MAX : dvd_r[DistW-1:0];
        bin_nxt   = dist_nxt;
        bcd_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_BCD;
      end
      ST_BCD: begin
        {bcd_nxt, bin_nxt} = {bcd_adj[BcdW-2:0], bin_r, 1'b0};
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(DistW - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_SCAN: begin
        seg_nxt   = ~scan_pat;
        case (scan_r)
          2'd1: begin
            dig_nxt  = 8'hFD;
            scan_nxt = 2'd2;
          end
          2'd2: begin
            dig_nxt  = 8'hFB;
            scan_nxt = 2'd0;
          end
          default: begin
            dig_nxt  = 8'hFE;
            scan_nxt = 2'd1;
          end
        endcase
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      bcd_r   <= BCD_RST;
      dist_r  <= DIST_RST;
      scan_r  <= '0;
      seg_r   <= PINS_OFF;
      dig_r   <= PINS_OFF;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      bcd_r   <= bcd_nxt;
      dist_r  <= dist_nxt;
      scan_r  <= scan_nxt;
      seg_r   <= seg_nxt;
      dig_r   <= dig_nxt;
    end
  end

  // Datapath shift registers need no reset.
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    bin_r <= bin_nxt;
  end

  // Output register: holds a finished result until its transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_seg_r   <= seg_r;
      out_dig_r   <= dig_r;
      out_red_r   <= red_lvl;
      out_green_r <= green_lvl;
      out_dist_r  <= dist_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_segment_pins      = out_seg_r;
  assign out_digit_select_pins = out_dig_r;
  assign out_red_led_pin       = out_red_r;
  assign out_green_led_pin     = out_green_r;
  assign out_distance_cm       = out_dist_r;

endmodule

`default_nettype wire

@@ sv/erdd_checker.sv @@
// ============================================================================
// erdd_checker
// Port-level checks for the echo range display driver, bound to the top level.
// ============================================================================
`default_nettype none

module erdd_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [erdd_pkg::SegW-1:0]         out_digit_select_pins,
  input wire logic                              out_red_led_pin,
  input wire logic                              out_green_led_pin,
  input wire logic [erdd_pkg::DistW-1:0]        out_distance_cm
);
  import erdd_pkg::*;

  // A result that is held back stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

  // An offered distance never leaves its saturated range.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_cm <= DIST_MAX)
    else $error("distance above saturation");

  // At least one zone LED is lit whenever a result is offered.
  a_led_zone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_red_led_pin && out_green_led_pin))
    else $error("both zone LEDs dark");

  // At most one digit is enabled, and only one of the three used.
  a_digit_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_select_pins == PINS_OFF ||
                   out_digit_select_pins == 8'hFE ||
                   out_digit_select_pins == 8'hFD ||
                   out_digit_select_pins == 8'hFB))
    else $error("bad digit select pattern");

endmodule

bind echo_range_display_driver_unit erdd_checker u_erdd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_digit_select_pins (out_digit_select_pins),
  .out_red_led_pin       (out_red_led_pin),
  .out_green_led_pin     (out_green_led_pin),
  .out_distance_cm       (out_distance_cm)
);

`default_nettype wire
